@@ sv/elt_pkg.sv @@
// Shared types and constants for the expression language tokenizer.
// Holds character classes, token kinds, scanner states and the token beat layout.
// No dependencies.
package elt_pkg;

  // Default lexeme length ceiling
  localparam int LEXEME_MAX_DEF = 255;

  // Queue depths between front, scanner and output
  localparam int CQ_DEPTH   = 2;
  localparam int OBUF_DEPTH = 4;

  // Characters with a role of their own
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_HASH  = "#";
  localparam logic [7:0] CH_QUOTE = "\"";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_S     = "s";
  localparam logic [7:0] CH_P     = "p";

  // Token kinds
  localparam logic [4:0] K_SEMI   = 5'd0;
  localparam logic [4:0] K_PLUS   = 5'd1;
  localparam logic [4:0] K_SUB    = 5'd2;
  localparam logic [4:0] K_STAR   = 5'd3;
  localparam logic [4:0] K_LBRK   = 5'd4;
  localparam logic [4:0] K_RBRK   = 5'd5;
  localparam logic [4:0] K_LPAR   = 5'd6;
  localparam logic [4:0] K_RPAR   = 5'd7;
  localparam logic [4:0] K_LBRC   = 5'd8;
  localparam logic [4:0] K_RBRC   = 5'd9;
  localparam logic [4:0] K_COMMA  = 5'd10;
  localparam logic [4:0] K_IDENT  = 5'd11;
  localparam logic [4:0] K_SET    = 5'd12;
  localparam logic [4:0] K_PRINT  = 5'd13;
  localparam logic [4:0] K_INT    = 5'd14;
  localparam logic [4:0] K_FLOAT  = 5'd15;
  localparam logic [4:0] K_STR    = 5'd16;
  localparam logic [4:0] K_ERROR  = 5'd17;
  localparam logic [4:0] K_DONE   = 5'd18;

  // Keyword tracking codes
  localparam logic [1:0] KW_NONE  = 2'd0;
  localparam logic [1:0] KW_SET   = 2'd1;
  localparam logic [1:0] KW_PRINT = 2'd2;

  // Character classes produced by the front
  typedef enum logic [3:0] {
    CL_BLANK,
    CL_NL,
    CL_ALPHA,
    CL_DIGIT,
    CL_HASH,
    CL_QUOTE,
    CL_MINUS,
    CL_DOT,
    CL_PUNCT,
    CL_OTHER,
    CL_END
  } cls_t;

  // Scanner states, one-hot
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_WORD  = 8'b0000_0010,
    ST_TEXT  = 8'b0000_0100,
    ST_INT   = 8'b0000_1000,
    ST_FRAC  = 8'b0001_0000,
    ST_NOTE  = 8'b0010_0000,
    ST_MINUS = 8'b0100_0000,
    ST_DOT   = 8'b1000_0000
  } scan_st_t;

  // Classified character
  typedef struct packed {
    cls_t       cls;
    logic [7:0] ch;
    logic [4:0] pkind;
  } item_t;

  // Head of the class queue as seen by the scanner
  typedef struct packed {
    logic  valid;
    item_t item;
  } cq_head_t;

  // One token beat
  typedef struct packed {
    logic [4:0]         kind;
    logic [15:0]        line;
    logic [31:0]        start_pos;
    logic [7:0]         length;
    logic signed [31:0] int_value;
    logic [31:0]        frac_value;
    logic [7:0]         frac_digits;
    logic               saturated;
    logic               last_of_run;
  } tok_t;

  // Up to two tokens written into the output buffer per cycle
  typedef struct packed {
    logic v0;
    logic v1;
    tok_t t0;
    tok_t t1;
  } tok_push_t;

endpackage

@@ sv/elt_in_if.sv @@
// Character channel of the tokenizer: valid/ready handshake with one byte per beat.
// No dependencies.
interface elt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       at_end;

  modport source (output valid, output ch, output at_end, input ready);
  modport sink   (input valid, input ch, input at_end, output ready);
endinterface

@@ sv/elt_out_if.sv @@
// Token channel of the tokenizer: valid/ready handshake with one token per beat.
// No dependencies.
interface elt_out_if;
  logic               valid;
  logic               ready;
  logic [4:0]         kind;
  logic [15:0]        line;
  logic [31:0]        start_pos;
  logic [7:0]         length;
  logic signed [31:0] int_value;
  logic [31:0]        frac_value;
  logic [7:0]         frac_digits;
  logic               saturated;
  logic               last_of_run;

  modport source (output valid, output kind, output line, output start_pos, output length,
                  output int_value, output frac_value, output frac_digits,
                  output saturated, output last_of_run, input ready);
  modport sink   (input valid, input kind, input line, input start_pos, input length,
                  input int_value, input frac_value, input frac_digits,
                  input saturated, input last_of_run, output ready);
endinterface

@@ sv/elt_front.sv @@
// Tokenizer front: takes character beats, classifies them and queues them.
// Depends on elt_pkg and elt_in_if.
module elt_front (
  input  logic             clk,
  input  logic             rst_n,
  elt_in_if.sink           in_ch,
  input  logic             pop,
  output elt_pkg::cq_head_t head
);
  import elt_pkg::*;

  localparam int AW = $clog2(CQ_DEPTH);
  localparam int CW = $clog2(CQ_DEPTH + 1);

  item_t         cls_item;
  item_t         q_r [CQ_DEPTH];
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [AW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          push;

  // Character classification
  always_comb begin
    cls_item.ch    = in_ch.ch;
    cls_item.pkind = K_ERROR;
    if (in_ch.at_end) begin
      cls_item.cls = CL_END;
    end else begin
      case (in_ch.ch) inside
        " ", 8'h09, 8'h0B, 8'h0C, 8'h0D:                  cls_item.cls = CL_BLANK;
        CH_NL:                                             cls_item.cls = CL_NL;
        ["a":"z"], ["A":"Z"]:                              cls_item.cls = CL_ALPHA;
        ["0":"9"]:                                         cls_item.cls = CL_DIGIT;
        CH_HASH:                                           cls_item.cls = CL_HASH;
        CH_QUOTE:                                          cls_item.cls = CL_QUOTE;
        CH_MINUS:                                          cls_item.cls = CL_MINUS;
        CH_DOT:                                            cls_item.cls = CL_DOT;
        ";", "+", "*", "[", "]", "(", ")", "{", "}", ",":  cls_item.cls = CL_PUNCT;
        default:                                           cls_item.cls = CL_OTHER;
      endcase
    end
    // Punctuation kind
    case (in_ch.ch)
      ";":     cls_item.pkind = K_SEMI;
      "+":     cls_item.pkind = K_PLUS;
      "*":     cls_item.pkind = K_STAR;
      "[":     cls_item.pkind = K_LBRK;
      "]":     cls_item.pkind = K_RBRK;
      "(":     cls_item.pkind = K_LPAR;
      ")":     cls_item.pkind = K_RPAR;
      "{":     cls_item.pkind = K_LBRC;
      "}":     cls_item.pkind = K_RBRC;
      ",":     cls_item.pkind = K_COMMA;
      default: cls_item.pkind = K_ERROR;
    endcase
  end

  // Queue control
  assign in_ch.ready = (cnt_r != CW'(CQ_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign head.valid  = (cnt_r != '0);
  assign head.item   = q_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + AW'(1) : wptr_r;
    rptr_nxt = pop ? rptr_r + AW'(1) : rptr_r;
    cnt_nxt  = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= cls_item;
    end
  end

`ifndef SYNTHESIS
  a_cq_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("class queue popped while empty");
`endif

endmodule

@@ sv/elt_scan.sv @@
// Tokenizer back end: scanner state machine over classified characters.
// Emits up to two token beats per character into the output buffer.
// Depends on elt_pkg.
module elt_scan #(
  parameter int LEXEME_MAX = elt_pkg::LEXEME_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  elt_pkg::cq_head_t  head,
  input  logic               space,
  output logic               pop,
  output elt_pkg::tok_push_t push
);
  import elt_pkg::*;

  localparam int LenW = $clog2(LEXEME_MAX + 1);

  scan_st_t           st_r, st_nxt;
  logic [15:0]        line_r, line_nxt;
  logic [31:0]        pos_r, pos_nxt;
  logic [31:0]        tstart_r, tstart_nxt;
  logic [LenW-1:0]    tlen_r, tlen_nxt;
  logic [1:0]         kw_r, kw_nxt;
  logic [31:0]        iacc_r, iacc_nxt;
  logic [31:0]        facc_r, facc_nxt;
  logic [7:0]         fcnt_r, fcnt_nxt;
  logic               neg_r, neg_nxt;
  logic               sat_r, sat_nxt;
  logic               fin_r, fin_nxt;

  logic               go;
  item_t              it;
  logic [3:0]         dval;
  logic [7:0]         len8;
  logic signed [31:0] ival_s;
  logic [LenW-1:0]    g_len;
  logic               g_sat;
  logic [35:0]        iv_w, fv_w, ilim;
  logic [31:0]        id_v, fd_v;
  logic               id_sat, fd_sat;
  logic [7:0]         fc_v;
  logic               fc_sat;
  tok_t               ft, e0, e1;
  logic               ft_v, e0_v, e1_v;
  logic               do_flush, do_idle;

  function automatic tok_t mk_tok(input logic [4:0] kind, input logic [15:0] ln,
                                  input logic [31:0] start, input logic [7:0] len,
                                  input logic signed [31:0] ival, input logic [31:0] fval,
                                  input logic [7:0] fdig, input logic sat);
    tok_t t;
    t.kind        = kind;
    t.line        = ln;
    t.start_pos   = start;
    t.length      = len;
    t.int_value   = ival;
    t.frac_value  = fval;
    t.frac_digits = fdig;
    t.saturated   = sat;
    t.last_of_run = 1'b0;
    return t;
  endfunction

  // Keyword match update for the character at lexeme index i (i >= 1)
  function automatic logic [1:0] kw_step(input logic [1:0] kw, input logic [LenW-1:0] i,
                                         input logic [7:0] c);
    logic [7:0] want;
    logic       ok;
    want = 8'h00;
    ok   = 1'b0;
    if (kw == KW_SET) begin
      case (i)
        LenW'(1): want = "e";
        LenW'(2): want = "t";
        default:  want = 8'h00;
      endcase
      ok = (i < LenW'(3)) && (want == c);
    end else if (kw == KW_PRINT) begin
      case (i)
        LenW'(1): want = "r";
        LenW'(2): want = "i";
        LenW'(3): want = "n";
        LenW'(4): want = "t";
        default:  want = 8'h00;
      endcase
      ok = (i < LenW'(5)) && (want == c);
    end
    return ok ? kw : KW_NONE;
  endfunction

  assign go   = head.valid && space;
  assign pop  = go;
  assign it   = head.item;
  assign dval = it.ch[3:0];
  assign len8 = 8'(tlen_r);

  // Lexeme growth, number accumulation
  always_comb begin
    ival_s = neg_r ? -$signed(iacc_r) : $signed(iacc_r);
    if (tlen_r < LenW'(LEXEME_MAX)) begin
      g_len = tlen_r + LenW'(1);
      g_sat = 1'b0;
    end else begin
      g_len = tlen_r;
      g_sat = 1'b1;
    end
    ilim = neg_r ? 36'h0_8000_0000 : 36'h0_7FFF_FFFF;
    iv_w = {1'b0, iacc_r, 3'b000} + {3'b000, iacc_r, 1'b0} + {32'h0, dval};
    if (iv_w > ilim) begin
      id_v   = ilim[31:0];
      id_sat = 1'b1;
    end else begin
      id_v   = iv_w[31:0];
      id_sat = 1'b0;
    end
    fv_w = {1'b0, facc_r, 3'b000} + {3'b000, facc_r, 1'b0} + {32'h0, dval};
    if (fv_w > 36'h0_FFFF_FFFF) begin
      fd_v   = 32'hFFFF_FFFF;
      fd_sat = 1'b1;
    end else begin
      fd_v   = fv_w[31:0];
      fd_sat = 1'b0;
    end
    if (fcnt_r != 8'hFF) begin
      fc_v   = fcnt_r + 8'd1;
      fc_sat = 1'b0;
    end else begin
      fc_v   = fcnt_r;
      fc_sat = 1'b1;
    end
  end

  // Token for the pending lexeme, if any
  always_comb begin
    ft_v = 1'b1;
    ft   = mk_tok(K_ERROR, line_r, tstart_r, len8, '0, '0, '0, sat_r);
    case (st_r)
      ST_WORD: begin
        if (kw_r == KW_SET && tlen_r == LenW'(3)) begin
          ft.kind = K_SET;
        end else if (kw_r == KW_PRINT && tlen_r == LenW'(5)) begin
          ft.kind = K_PRINT;
        end else begin
          ft.kind = K_IDENT;
        end
      end
      ST_INT:   ft = mk_tok(K_INT, line_r, tstart_r, len8, ival_s, '0, '0, sat_r);
      ST_FRAC:  ft = mk_tok(K_FLOAT, line_r, tstart_r, len8, ival_s, facc_r, fcnt_r, sat_r);
      ST_MINUS: ft = mk_tok(K_SUB, line_r, tstart_r, 8'd1, '0, '0, '0, 1'b0);
      ST_DOT:   ft = mk_tok(K_ERROR, line_r, tstart_r, len8, '0, '0, '0, sat_r);
      default:  ft_v = 1'b0;
    endcase
  end

  // Scanner next state and emitted tokens
  always_comb begin
    st_nxt     = st_r;
    line_nxt   = line_r;
    pos_nxt    = pos_r;
    tstart_nxt = tstart_r;
    tlen_nxt   = tlen_r;
    kw_nxt     = kw_r;
    iacc_nxt   = iacc_r;
    facc_nxt   = facc_r;
    fcnt_nxt   = fcnt_r;
    neg_nxt    = neg_r;
    sat_nxt    = sat_r;
    fin_nxt    = fin_r;
    e0_v       = 1'b0;
    e1_v       = 1'b0;
    e0         = '0;
    e1         = '0;
    do_flush   = 1'b0;
    do_idle    = 1'b0;

    if (go) begin
      if (fin_r) begin
        e1_v = 1'b1;
        e1   = mk_tok(K_DONE, line_r, pos_r, '0, '0, '0, '0, 1'b0);
      end else if (it.cls == CL_END) begin
        do_flush = 1'b1;
        e1_v     = 1'b1;
        e1       = mk_tok(K_DONE, line_r, pos_r, '0, '0, '0, '0, 1'b0);
        fin_nxt  = 1'b1;
      end else begin
        pos_nxt = pos_r + 32'd1;
        if (it.cls == CL_NL) begin
          // newline closes everything; an open string becomes an error
          if (st_r == ST_TEXT) begin
            e0_v = 1'b1;
            e0   = mk_tok(K_ERROR, line_r, tstart_r, len8, '0, '0, '0, sat_r);
          end else begin
            do_flush = 1'b1;
          end
          st_nxt = ST_IDLE;
          if (line_r != 16'hFFFF) begin
            line_nxt = line_r + 16'd1;
          end
        end else begin
          case (st_r)
            ST_IDLE: do_idle = 1'b1;
            ST_NOTE: ;
            ST_TEXT: begin
              if (it.cls == CL_QUOTE) begin
                e0_v   = 1'b1;
                e0     = mk_tok(K_STR, line_r, tstart_r, len8, '0, '0, '0, sat_r);
                st_nxt = ST_IDLE;
              end else begin
                tlen_nxt = g_len;
                sat_nxt  = sat_r | g_sat;
              end
            end
            ST_WORD: begin
              if (it.cls == CL_ALPHA || it.cls == CL_DIGIT) begin
                kw_nxt   = kw_step(kw_r, tlen_r, it.ch);
                tlen_nxt = g_len;
                sat_nxt  = sat_r | g_sat;
              end else begin
                do_flush = 1'b1;
                do_idle  = 1'b1;
              end
            end
            ST_INT: begin
              if (it.cls == CL_DIGIT) begin
                tlen_nxt = g_len;
                iacc_nxt = id_v;
                sat_nxt  = sat_r | g_sat | id_sat;
              end else if (it.cls == CL_DOT) begin
                tlen_nxt = g_len;
                sat_nxt  = sat_r | g_sat;
                st_nxt   = ST_DOT;
              end else begin
                do_flush = 1'b1;
                do_idle  = 1'b1;
              end
            end
            ST_DOT, ST_FRAC: begin
              if (it.cls == CL_DIGIT) begin
                tlen_nxt = g_len;
                facc_nxt = fd_v;
                fcnt_nxt = fc_v;
                sat_nxt  = sat_r | g_sat | fd_sat | fc_sat;
                st_nxt   = ST_FRAC;
              end else begin
                do_flush = 1'b1;
                do_idle  = 1'b1;
              end
            end
            ST_MINUS: begin
              // accumulator is clear here, so a single digit never saturates
              if (it.cls == CL_DIGIT) begin
                neg_nxt  = 1'b1;
                tlen_nxt = g_len;
                sat_nxt  = sat_r | g_sat;
                iacc_nxt = {28'h0, dval};
                st_nxt   = ST_INT;
              end else begin
                do_flush = 1'b1;
                do_idle  = 1'b1;
              end
            end
            default: st_nxt = ST_IDLE;
          endcase
        end
      end

      // Close the pending lexeme
      if (do_flush) begin
        e0_v   = ft_v;
        e0     = ft;
        st_nxt = ST_IDLE;
      end

      // Character seen between tokens
      if (do_idle) begin
        st_nxt = ST_IDLE;
        case (it.cls)
          CL_BLANK: ;
          CL_HASH:  st_nxt = ST_NOTE;
          CL_ALPHA, CL_DIGIT, CL_QUOTE, CL_MINUS: begin
            tstart_nxt = pos_r;
            tlen_nxt   = LenW'(1);
            kw_nxt     = KW_NONE;
            iacc_nxt   = '0;
            facc_nxt   = '0;
            fcnt_nxt   = '0;
            neg_nxt    = 1'b0;
            sat_nxt    = 1'b0;
            case (it.cls)
              CL_ALPHA: begin
                st_nxt = ST_WORD;
                if (it.ch == CH_S) begin
                  kw_nxt = KW_SET;
                end else if (it.ch == CH_P) begin
                  kw_nxt = KW_PRINT;
                end
              end
              CL_DIGIT: begin
                st_nxt   = ST_INT;
                iacc_nxt = {28'h0, dval};
              end
              CL_QUOTE: begin
                st_nxt     = ST_TEXT;
                tstart_nxt = pos_r + 32'd1;
                tlen_nxt   = '0;
              end
              default:  st_nxt = ST_MINUS;
            endcase
          end
          CL_PUNCT: begin
            e1_v = 1'b1;
            e1   = mk_tok(it.pkind, line_r, pos_r, 8'd1, '0, '0, '0, 1'b0);
          end
          default: begin
            e1_v = 1'b1;
            e1   = mk_tok(K_ERROR, line_r, pos_r, 8'd1, '0, '0, '0, 1'b0);
          end
        endcase
      end
    end
  end

  // Pack emitted tokens in order, mark the last one
  always_comb begin
    push.v0 = e0_v | e1_v;
    push.v1 = e0_v & e1_v;
    push.t0 = e0_v ? e0 : e1;
    push.t1 = e1;
    push.t0.last_of_run = !(e0_v & e1_v);
    push.t1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      line_r   <= '0;
      pos_r    <= '0;
      tstart_r <= '0;
      tlen_r   <= '0;
      kw_r     <= KW_NONE;
      iacc_r   <= '0;
      facc_r   <= '0;
      fcnt_r   <= '0;
      neg_r    <= 1'b0;
      sat_r    <= 1'b0;
      fin_r    <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      line_r   <= line_nxt;
      pos_r    <= pos_nxt;
      tstart_r <= tstart_nxt;
      tlen_r   <= tlen_nxt;
      kw_r     <= kw_nxt;
      iacc_r   <= iacc_nxt;
      facc_r   <= facc_nxt;
      fcnt_r   <= fcnt_nxt;
      neg_r    <= neg_nxt;
      sat_r    <= sat_nxt;
      fin_r    <= fin_nxt;
    end
  end

`ifndef SYNTHESIS
  a_fin_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |=> fin_r)
    else $error("finished flag dropped without reset");
  a_done_only: assert property (@(posedge clk) disable iff (!rst_n)
    (go && fin_r) |-> (push.v0 && !push.v1 && push.t0.kind == K_DONE))
    else $error("item after done did not give a single done token");
  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    (go && !fin_r && it.cls != CL_END) |=> (pos_r == $past(pos_r) + 32'd1))
    else $error("position did not advance on a character");
`endif

endmodule

@@ sv/elt_obuf.sv @@
// Tokenizer output buffer: small FIFO taking up to two tokens per cycle.
// Drives the token channel. Depends on elt_pkg and elt_out_if.
module elt_obuf (
  input  logic               clk,
  input  logic               rst_n,
  input  elt_pkg::tok_push_t push,
  output logic               space,
  elt_out_if.source          out_tok
);
  import elt_pkg::*;

  localparam int AW = $clog2(OBUF_DEPTH);
  localparam int CW = AW + 1;

  tok_t          ob_r [OBUF_DEPTH];
  tok_t          hd;
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [AW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;

  // Room for a two-token beat pair
  assign space = (cnt_r <= CW'(OBUF_DEPTH - 2));
  assign pop   = out_tok.valid && out_tok.ready;

  always_comb begin
    wptr_nxt = wptr_r + AW'(push.v0) + AW'(push.v1);
    rptr_nxt = pop ? rptr_r + AW'(1) : rptr_r;
    cnt_nxt  = cnt_r + CW'(push.v0) + CW'(push.v1) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push.v0) begin
      ob_r[wptr_r] <= push.t0;
    end
    if (push.v1) begin
      ob_r[wptr_r + AW'(1)] <= push.t1;
    end
  end

  // Head beat to the channel
  assign hd                  = ob_r[rptr_r];
  assign out_tok.valid       = (cnt_r != '0);
  assign out_tok.kind        = hd.kind;
  assign out_tok.line        = hd.line;
  assign out_tok.start_pos   = hd.start_pos;
  assign out_tok.length      = hd.length;
  assign out_tok.int_value   = hd.int_value;
  assign out_tok.frac_value  = hd.frac_value;
  assign out_tok.frac_digits = hd.frac_digits;
  assign out_tok.saturated   = hd.saturated;
  assign out_tok.last_of_run = hd.last_of_run;

`ifndef SYNTHESIS
  a_ob_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.v0 |-> (cnt_r <= CW'(OBUF_DEPTH - 2)))
    else $error("tokens pushed without room for two");
  a_ob_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.v1 |-> (push.v0 && !push.t0.last_of_run && push.t1.last_of_run))
    else $error("second token without first or with wrong last marker");
`endif

endmodule

@@ sv/expression_language_tokenizer.sv @@
// Expression language tokenizer, top level.
// Depends on elt_pkg, elt_in_if, elt_out_if, elt_front, elt_scan and elt_obuf.
//
// Usage:
//   in_ch carries one character per beat (ch), or an end marker (at_end = 1).
//   out_tok carries tokens: kind, line, start_pos, length, numeric fields,
//   saturated, and last_of_run on the final token caused by a character.
//   A character gives zero, one or two tokens; an end marker flushes a
//   pending token and gives done; later beats each give one more done.
// Path: the beat that completes a token is registered in the class queue,
//   then the scanner writes the token into the output buffer, which
//   presents it on out_tok; the scanner waits while that buffer is full.
// Throughput: one character per cycle sustained. The scanner takes a
//   character whenever the 4-entry output buffer has room for two tokens;
//   with out_tok.ready high the buffer drains one token a cycle, so only
//   bursts of two-token characters can fill it.
// Stall: when out_tok.ready is low the buffer fills, the scanner stops, the
//   2-entry class queue fills and in_ch.ready drops. Nothing is lost.
// Reset: rst_n low (synchronous) empties both queues and returns the
//   scanner to idle with line and position at zero.
module expression_language_tokenizer #(
  parameter int LEXEME_MAX = elt_pkg::LEXEME_MAX_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  elt_in_if.sink    in_ch,
  elt_out_if.source out_tok
);
  import elt_pkg::*;

  cq_head_t  head;
  logic      pop;
  logic      space;
  tok_push_t push;

  // Classify and queue characters
  elt_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .pop   (pop),
    .head  (head)
  );

  // Scanner
  elt_scan #(
    .LEXEME_MAX (LEXEME_MAX)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .head  (head),
    .space (space),
    .pop   (pop),
    .push  (push)
  );

  // Output buffer
  elt_obuf u_obuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .space   (space),
    .out_tok (out_tok)
  );

endmodule
